// File: hdl/countdown_minute_second_display_macros.svh
// Assertion macros used by the checker file of the countdown display block.
`ifndef COUNTDOWN_MINUTE_SECOND_DISPLAY_MACROS_SVH
`define COUNTDOWN_MINUTE_SECOND_DISPLAY_MACROS_SVH

// Implication checked in the same cycle, disabled while reset is active.
`define CMSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmsd check failed");

// Implication checked in the next cycle, disabled while reset is active.
`define CMSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmsd check failed");

`endif

// File: hdl/cmsd_pkg.sv
// Shared types and constants of the countdown minutes:seconds display block.
package cmsd_pkg;

    localparam int COUNT_W = 14;

    typedef logic signed [COUNT_W-1:0] count_t;

    // Request operation codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_REFRESH = 2'd1;
    localparam logic [1:0] OP_LOAD    = 2'd2;

    // Count limits
    localparam count_t LOAD_MIN  = -14'sd600;
    localparam count_t LOAD_MAX  = 14'sd5999;
    localparam count_t COUNT_MIN = -14'sd8192;

    // Overrun magnitude after which counting stops
    localparam int OVERRUN_LIMIT = 599;

    // Digit code shown in place of the leading digit for negative counts
    localparam logic [3:0] MINUS_CODE = 4'd10;

    typedef struct packed {
        logic colon;
        logic run;
        logic overtime;
        logic counted;
    } flags_t;

    typedef struct packed {
        count_t count;
        flags_t flags;
    } snap_t;

endpackage

// File: hdl/cmsd_state.sv
// Request register and timer state update of the countdown display block.
module cmsd_state
    import cmsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   operation,
    input  logic signed [13:0] load_seconds,
    input  logic         load_run,
    input  logic         channel_free,
    output logic         snap_valid,
    input  logic         snap_stall,
    output snap_t        snap
);

    localparam count_t OVERRUN_FLOOR = count_t'(-OVERRUN_LIMIT);

    logic       req_valid_reg, req_valid_next;
    logic [1:0] op_reg;
    count_t     load_seconds_reg;
    logic       load_run_reg;
    logic       channel_free_reg;

    count_t count_reg, count_next;
    logic   run_reg, run_next;
    logic   refreshed_reg, refreshed_next;
    logic   colon_reg, colon_next;
    logic   overtime_reg, overtime_next;
    logic   counted_reg, counted_next;
    logic   snap_valid_reg, snap_valid_next;

    logic   snap_ready;
    logic   advance;
    logic   in_take;
    count_t count_dec;
    count_t load_clamped;

    // Handshake between the request register and the state snapshot
    assign snap_ready = !snap_valid_reg || !snap_stall;
    assign advance    = req_valid_reg && snap_ready;
    assign in_stall   = req_valid_reg && !snap_ready;
    assign in_take    = in_valid && !in_stall;

    // Hold the request until the state update takes it
    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (in_take)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg           <= operation;
            load_seconds_reg <= load_seconds;
            load_run_reg     <= load_run;
            channel_free_reg <= channel_free;
        end
    end

    // Decrement with saturation at the most negative count
    assign count_dec = (count_reg != COUNT_MIN) ? count_t'(count_reg - 14'sd1) : count_reg;

    // Clamp the loaded count to its legal range
    always_comb
    begin
        load_clamped = load_seconds_reg;
        if (load_seconds_reg < LOAD_MIN)
        begin
            load_clamped = LOAD_MIN;
        end
        else if (load_seconds_reg > LOAD_MAX)
        begin
            load_clamped = LOAD_MAX;
        end
    end

    // Work out the timer state after the request
    always_comb
    begin
        count_next     = count_reg;
        run_next       = run_reg;
        refreshed_next = refreshed_reg;
        colon_next     = colon_reg;
        overtime_next  = overtime_reg;
        counted_next   = counted_reg;
        case (op_reg)
            OP_TICK:
            begin
                if (refreshed_reg)
                begin
                    if (run_reg && channel_free_reg)
                    begin
                        counted_next = 1'b1;
                        count_next   = count_dec;
                        if (count_dec < 14'sd0)
                        begin
                            overtime_next = 1'b1;
                            if (count_dec < OVERRUN_FLOOR)
                            begin
                                run_next = 1'b0;
                            end
                        end
                    end
                    refreshed_next = 1'b0;
                end
            end
            OP_REFRESH:
            begin
                if (!refreshed_reg)
                begin
                    colon_next     = 1'b1;
                    refreshed_next = 1'b1;
                end
                else
                begin
                    colon_next = !colon_reg;
                end
            end
            OP_LOAD:
            begin
                count_next    = load_clamped;
                run_next      = load_run_reg;
                overtime_next = 1'b0;
                counted_next  = 1'b0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Mark the snapshot full on update, drop it once taken
    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (advance)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_ready)
        begin
            snap_valid_next = 1'b0;
        end
    end

    // Advance the timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            run_reg        <= 1'b0;
            refreshed_reg  <= 1'b0;
            colon_reg      <= 1'b0;
            overtime_reg   <= 1'b0;
            counted_reg    <= 1'b0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            if (advance)
            begin
                count_reg     <= count_next;
                run_reg       <= run_next;
                refreshed_reg <= refreshed_next;
                colon_reg     <= colon_next;
                overtime_reg  <= overtime_next;
                counted_reg   <= counted_next;
            end
        end
    end

    // The state registers are the snapshot, held while it waits
    assign snap_valid           = snap_valid_reg;
    assign snap.count           = count_reg;
    assign snap.flags.colon     = colon_reg;
    assign snap.flags.run       = run_reg;
    assign snap.flags.overtime  = overtime_reg;
    assign snap.flags.counted   = counted_reg;

endmodule

// File: hdl/cmsd_split.sv
// Two-stage split of the signed count into minutes and seconds digits.
module cmsd_split
    import cmsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       snap_valid,
    output logic       snap_stall,
    input  snap_t      snap,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] digit_min_tens,
    output logic [3:0] digit_min_ones,
    output logic [2:0] digit_sec_tens,
    output logic [3:0] digit_sec_ones,
    output flags_t     flags
);

    // Reciprocal of sixty scaled by two to the twentieth, exact for 14-bit values
    localparam logic [14:0] RECIP60       = 15'd17477;
    localparam int          RECIP60_SHIFT = 20;
    // Reciprocal of ten scaled by two to the eleventh, exact below 1029
    localparam logic [7:0]  RECIP10       = 8'd205;
    localparam int          RECIP10_SHIFT = 11;

    // Tens digit of a seconds value below sixty
    function automatic logic [2:0] sec_tens_of(input logic [5:0] secs);
        logic [2:0] tens;
        begin
            if (secs >= 6'd50)
            begin
                tens = 3'd5;
            end
            else if (secs >= 6'd40)
            begin
                tens = 3'd4;
            end
            else if (secs >= 6'd30)
            begin
                tens = 3'd3;
            end
            else if (secs >= 6'd20)
            begin
                tens = 3'd2;
            end
            else if (secs >= 6'd10)
            begin
                tens = 3'd1;
            end
            else
            begin
                tens = 3'd0;
            end
            return tens;
        end
    endfunction

    logic        a_valid_reg, a_valid_next;
    logic        neg_reg;
    logic [13:0] mag_reg;
    logic [7:0]  mins_reg;
    flags_t      a_flags_reg;

    logic        b_valid_reg, b_valid_next;
    logic [3:0]  min_tens_reg;
    logic [3:0]  min_ones_reg;
    logic [2:0]  sec_tens_reg;
    logic [3:0]  sec_ones_reg;
    flags_t      b_flags_reg;

    logic        a_ready;
    logic        b_ready;
    logic        a_take;
    logic        b_take;
    logic        neg;
    logic [13:0] count_bits;
    logic [13:0] mag;
    logic [28:0] mins_prod;
    logic [13:0] mins_times60;
    logic [13:0] secs_full;
    logic [5:0]  secs;
    logic [15:0] tens_prod;
    logic [3:0]  min_tens;
    logic [7:0]  min_ones_full;
    logic [2:0]  sec_tens;
    logic [5:0]  sec_ones_full;

    // Stage handshakes
    assign b_ready    = !b_valid_reg || !out_stall;
    assign a_ready    = !a_valid_reg || b_ready;
    assign snap_stall = a_valid_reg && !b_ready;
    assign a_take     = snap_valid && a_ready;
    assign b_take     = a_valid_reg && b_ready;

    // Magnitude and minutes quotient
    assign count_bits = snap.count;
    assign neg        = snap.count[COUNT_W-1];
    assign mag        = neg ? 14'(~count_bits + 14'd1) : count_bits;
    assign mins_prod  = mag * RECIP60;

    // Seconds remainder and the decimal digits
    assign mins_times60  = {6'd0, mins_reg} * 14'd60;
    assign secs_full     = mag_reg - mins_times60;
    assign secs          = secs_full[5:0];
    assign tens_prod     = {8'd0, mins_reg} * {8'd0, RECIP10};
    assign min_tens      = tens_prod[RECIP10_SHIFT+3:RECIP10_SHIFT];
    assign min_ones_full = mins_reg - ({4'd0, min_tens} * 8'd10);
    assign sec_tens      = sec_tens_of(secs);
    assign sec_ones_full = secs - ({3'd0, sec_tens} * 6'd10);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_take)
        begin
            a_valid_next = 1'b1;
        end
        else if (b_ready)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (b_take)
        begin
            b_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            b_valid_next = 1'b0;
        end
    end

    // Hold stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Register magnitude and minutes
    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            neg_reg     <= neg;
            mag_reg     <= mag;
            mins_reg    <= mins_prod[RECIP60_SHIFT+7:RECIP60_SHIFT];
            a_flags_reg <= snap.flags;
        end
    end

    // Register the result digits
    always_ff @(posedge clk)
    begin
        if (b_take)
        begin
            min_tens_reg <= neg_reg ? MINUS_CODE : min_tens;
            min_ones_reg <= min_ones_full[3:0];
            sec_tens_reg <= sec_tens;
            sec_ones_reg <= sec_ones_full[3:0];
            b_flags_reg  <= a_flags_reg;
        end
    end

    assign out_valid      = b_valid_reg;
    assign digit_min_tens = min_tens_reg;
    assign digit_min_ones = min_ones_reg;
    assign digit_sec_tens = sec_tens_reg;
    assign digit_sec_ones = sec_ones_reg;
    assign flags          = b_flags_reg;

endmodule

// File: hdl/countdown_minute_second_display.sv
// Top level of the countdown timer with minutes:seconds display digits.
// Throughput: one request per cycle while out_stall is low; the state update feeds back on its own registers.
// Request register, state snapshot, minutes stage and result register each hold one item.
// Reset clears the count, the run, colon and sticky flags, and all stage valids.
module countdown_minute_second_display
    import cmsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic signed [13:0] load_seconds,
    input  logic       load_run,
    input  logic       channel_free,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] digit_min_tens,
    output logic [3:0] digit_min_ones,
    output logic [2:0] digit_sec_tens,
    output logic [3:0] digit_sec_ones,
    output logic       colon_lit,
    output logic       running,
    output logic       overtime,
    output logic       counted
);

    logic   snap_valid;
    logic   snap_stall;
    snap_t  snap;
    flags_t flags;

    // Timer state update
    cmsd_state u_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .load_seconds (load_seconds),
        .load_run     (load_run),
        .channel_free (channel_free),
        .snap_valid   (snap_valid),
        .snap_stall   (snap_stall),
        .snap         (snap)
    );

    // Display digit split
    cmsd_split u_split (
        .clk            (clk),
        .rst_n          (rst_n),
        .snap_valid     (snap_valid),
        .snap_stall     (snap_stall),
        .snap           (snap),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digit_min_tens (digit_min_tens),
        .digit_min_ones (digit_min_ones),
        .digit_sec_tens (digit_sec_tens),
        .digit_sec_ones (digit_sec_ones),
        .flags          (flags)
    );

    assign colon_lit = flags.colon;
    assign running   = flags.run;
    assign overtime  = flags.overtime;
    assign counted   = flags.counted;

endmodule

// File: hdl/cmsd_checker.sv
// Port-level checks of the countdown display block and their binding.
`include "countdown_minute_second_display_macros.svh"

module cmsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] digit_min_tens,
    input logic [3:0] digit_min_ones,
    input logic [2:0] digit_sec_tens,
    input logic [3:0] digit_sec_ones,
    input logic       overtime,
    input logic       counted
);

    logic        digits_legal;
    logic        held;
    logic [14:0] shown;

    // Collect the digit codes and the held state of the result channel
    assign digits_legal = (digit_min_tens <= 4'd10) && (digit_min_ones <= 4'd9) &&
                          (digit_sec_tens <= 3'd5) && (digit_sec_ones <= 4'd9);
    assign held         = out_valid && out_stall;
    assign shown        = {digit_min_tens, digit_min_ones, digit_sec_tens, digit_sec_ones};

    // Requests back up only when every stage is full and the output is held
    `CMSD_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, in_stall, out_valid && out_stall)

    // Every shown digit is a legal code
    `CMSD_ASSERT_SAME(a_digit_range, clk, rst_n, out_valid, digits_legal)

    // Overtime can only follow a decrement
    `CMSD_ASSERT_SAME(a_overtime_needs_count, clk, rst_n, out_valid && overtime, counted)

    // A held result keeps its digits
    `CMSD_ASSERT_NEXT(a_held_result, clk, rst_n, held, out_valid && $stable(shown))

endmodule

bind countdown_minute_second_display cmsd_checker u_cmsd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digit_min_tens (digit_min_tens),
    .digit_min_ones (digit_min_ones),
    .digit_sec_tens (digit_sec_tens),
    .digit_sec_ones (digit_sec_ones),
    .overtime       (overtime),
    .counted        (counted)
);
